FILE: hdl/tdsort_pkg.sv
// Package: widths, payload structs and state codes of the threshold sort unit.
`default_nettype none
package tdsort_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned IdW        = 32;
  localparam int unsigned ScoreW     = 16;
  localparam int unsigned EntryW     = IdW + ScoreW;

  typedef struct packed {
    logic [IdW-1:0]           entry_id;
    logic signed [ScoreW-1:0] score;
    logic                     last_entry;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]           out_id;
    logic signed [ScoreW-1:0] out_score;
    logic                     last_result;
    logic                     none_found;
    logic                     overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

endpackage
`default_nettype wire

FILE: hdl/tdsort_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tdsort_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/threshold_descending_sort_unit.sv
// Top level: threshold-filtered descending sort over a RAM-held entry set.
//
// Input: an item is taken when start is high and busy is low. Items of a set
// load one per cycle into the entry RAM; busy stays low while loading. The
// item with last_entry set ends the set (it is stored too if room remains;
// items past 64 are dropped and flag overflow on every result of the run).
// After the last item busy rises and the block runs selection passes over
// the RAM: each pass reads all N stored entries, one per cycle, and picks
// the highest qualifying score not yet emitted (earliest arrival on ties).
// A result leaves one pass after it is found, so a run of K results takes
// K+1 passes. Each result shows on
// res_o for exactly one cycle with res_valid_o high; the receiver cannot
// stall. If nothing meets the threshold one result with none_found comes.
// Config: cfg_data_i is taken when cfg_valid_i is high (cfg_ready_o is
// always high); write only while idle. Reset clears the threshold to 0 and
// empties the set; the RAM itself is not cleared.
`default_nettype none
module threshold_descending_sort_unit
  import tdsort_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          item_i,
  output logic                   res_valid_o,
  output result_t                res_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic signed [ScoreW-1:0] cfg_data_i
);

  state_e                  state_q, state_d;
  logic signed [ScoreW-1:0] thr_q;
  logic [CntW-1:0]         count_q, count_d;
  logic                    ovf_q, ovf_d;
  logic [CntW-1:0]         scan_q, scan_d;
  logic                    rdv_q;
  logic [IdxW-1:0]         rdidx_q;
  logic                    best_v_q, best_v_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic [EntryW-1:0]       best_q, best_d;
  logic                    pend_v_q, pend_v_d;
  logic [EntryW-1:0]       pend_q, pend_d;
  logic [IdxW-1:0]         pend_idx_q, pend_idx_d;
  logic                    res_v_d;
  result_t                 res_d;

  logic                    accept;
  logic                    we;
  logic [IdxW-1:0]         raddr;
  logic [EntryW-1:0]       rdata;
  logic signed [ScoreW-1:0] rd_score;
  logic signed [ScoreW-1:0] best_score;
  logic signed [ScoreW-1:0] pend_score;
  logic                    fresh;
  logic                    take;

  assign busy        = (state_q != ST_LOAD);
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign we          = accept && (count_q < CntW'(MaxEntries));
  assign raddr       = scan_q[IdxW-1:0];
  assign rd_score    = $signed(rdata[ScoreW-1:0]);
  assign best_score  = $signed(best_q[ScoreW-1:0]);
  assign pend_score  = $signed(pend_q[ScoreW-1:0]);
  assign fresh       = !pend_v_q || (rd_score < pend_score) ||
                       ((rd_score == pend_score) && (rdidx_q > pend_idx_q));
  assign take        = rdv_q && fresh && (rd_score >= thr_q) &&
                       (!best_v_q || (rd_score > best_score));

  tdsort_ram #(
    .Width(EntryW),
    .Depth(MaxEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i({item_i.entry_id, item_i.score}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    scan_d     = scan_q;
    best_v_d   = best_v_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    res_v_d    = 1'b0;
    res_d      = res_o;

    if (take) begin
      best_v_d   = 1'b1;
      best_idx_d = rdidx_q;
      best_d     = rdata;
    end

    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (we) begin
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last_entry) begin
            state_d  = ST_SCAN;
            scan_d   = '0;
            best_v_d = 1'b0;
            pend_v_d = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_q < count_q) begin
          scan_d = scan_q + CntW'(1);
        end else begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d.overflow   = ovf_q;
        res_d.none_found = 1'b0;
        res_d.out_id     = pend_q[EntryW-1:ScoreW];
        res_d.out_score  = $signed(pend_q[ScoreW-1:0]);
        if (best_v_q) begin
          res_v_d             = pend_v_q;
          res_d.last_result   = 1'b0;
          pend_v_d            = 1'b1;
          pend_d              = best_q;
          pend_idx_d          = best_idx_q;
          best_v_d            = 1'b0;
          scan_d              = '0;
          state_d             = ST_SCAN;
        end else begin
          res_v_d           = 1'b1;
          res_d.last_result = 1'b1;
          if (!pend_v_q) begin
            res_d.none_found = 1'b1;
            res_d.out_id     = '0;
            res_d.out_score  = '0;
          end
          pend_v_d = 1'b0;
          count_d  = '0;
          ovf_d    = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      thr_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      scan_q      <= '0;
      rdv_q       <= 1'b0;
      best_v_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      scan_q      <= scan_d;
      rdv_q       <= (state_q == ST_SCAN) && (scan_q < count_q);
      best_v_q    <= best_v_d;
      pend_v_q    <= pend_v_d;
      res_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rdidx_q    <= raddr;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    pend_q     <= pend_d;
    pend_idx_q <= pend_idx_d;
    res_o      <= res_d;
  end

endmodule
`default_nettype wire

FILE: hdl/tdsort_checker.sv
// Port-level checker for the threshold sort unit, bound to the top level.
`default_nettype none
module tdsort_checker
  import tdsort_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire in_item_t item_i,
  input wire logic     res_valid_o,
  input wire result_t  res_o
);

  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |-> busy)
    else $error("non-final result while idle");

  a_none_found_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.none_found |-> res_o.last_result && (res_o.out_id == '0))
    else $error("malformed none_found result");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !item_i.last_entry |=> !busy)
    else $error("busy after non-final item");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back-to-back results");

endmodule

bind threshold_descending_sort_unit tdsort_checker u_tdsort_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .item_i     (item_i),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
`default_nettype wire
